FILE: rtl/pwsg_pkg.sv
// shared types and constants of the pyramid window scan generator
// used by pwsg_ctrl, pwsg_dp, the top level and the testbench; depends on nothing
package pwsg_pkg;

    localparam int WIN_BITS     = 8;
    localparam int RATIO_BITS   = 16;
    localparam int LEVEL_BITS   = 6;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DAT_BITS = 16;
    localparam int Q_SHIFT      = 12;

    localparam logic [RATIO_BITS-1:0] Q_ONE     = RATIO_BITS'(4096);
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = LEVEL_BITS'(63);

    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;
    localparam logic [WIN_BITS-1:0]   RST_WINDOW_WIDTH  = WIN_BITS'(36);
    localparam logic [WIN_BITS-1:0]   RST_WINDOW_HEIGHT = WIN_BITS'(36);
    localparam logic [WIN_BITS-1:0]   RST_SCAN_STEP     = WIN_BITS'(1);
    localparam logic [RATIO_BITS-1:0] RST_RATIO_Q12     = RATIO_BITS'(4915);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_WINDOW_WIDTH  = 3'd2,
        CFG_WINDOW_HEIGHT = 3'd3,
        CFG_SCAN_STEP     = 3'd4,
        CFG_RATIO_Q12     = 3'd5
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_COL,
        S_ROW,
        S_EMIT,
        S_ADV,
        S_SHW,
        S_SHH,
        S_SZA,
        S_SZB,
        S_SZFIN
    } t_state;

    typedef enum logic [2:0] {
        DIV_COL,
        DIV_ROW,
        DIV_SHW,
        DIV_SHH,
        DIV_SZA,
        DIV_SZB
    } t_div_op;

    typedef enum logic [1:0] {
        ADV_COL,
        ADV_ROW,
        ADV_SHRINK,
        ADV_END
    } t_adv;

    typedef struct packed {
        logic    accept;
        logic    div_start;
        t_div_op div_op;
        logic    emit;
        logic    adv;
        logic    size_fin;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic scan_done;
        logic out_free;
        t_adv adv_kind;
    } t_dp_stat;

endpackage

FILE: rtl/pwsg_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// standalone; a zero divisor gives a zero quotient at once
module pwsg_div #(
    parameter int DW  = 25,
    parameter int DVW = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_done,
    output logic [DW-1:0]  o_quotient
);

    localparam int CNTW = $clog2(DW);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DW - 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DVW-1:0]  r_rem;
    logic [DW-1:0]   r_quo;
    logic [DVW-1:0]  r_dvs;

    logic [DVW:0]   rem_sh;
    logic [DVW+1:0] diff;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (i_divisor == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= (i_divisor == '0) ? '0 : i_dividend;
        end else if (r_busy) begin
            if (!diff[DVW+1]) begin
                r_rem <= diff[DVW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DVW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/pwsg_ctrl.sv
// controller state machine sequencing one window request
// depends on pwsg_pkg for state, command and status types
module pwsg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pwsg_pkg::t_dp_stat i_stat,
    output pwsg_pkg::t_dp_cmd  o_cmd
);

    pwsg_pkg::t_state r_state;
    pwsg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwsg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pwsg_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pwsg_pkg::S_CHECK;
            end
            pwsg_pkg::S_CHECK: begin
                n_state = i_stat.scan_done ? pwsg_pkg::S_EMIT : pwsg_pkg::S_COL;
            end
            pwsg_pkg::S_COL: begin
                if (i_stat.div_done) n_state = pwsg_pkg::S_ROW;
            end
            pwsg_pkg::S_ROW: begin
                if (i_stat.div_done) n_state = pwsg_pkg::S_EMIT;
            end
            pwsg_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.scan_done ? pwsg_pkg::S_IDLE : pwsg_pkg::S_ADV;
                end
            end
            pwsg_pkg::S_ADV: begin
                n_state = (i_stat.adv_kind == pwsg_pkg::ADV_SHRINK) ?
                          pwsg_pkg::S_SHW : pwsg_pkg::S_IDLE;
            end
            pwsg_pkg::S_SHW: begin
                if (i_stat.div_done) n_state = pwsg_pkg::S_SHH;
            end
            pwsg_pkg::S_SHH: begin
                if (i_stat.div_done) n_state = pwsg_pkg::S_SZA;
            end
            pwsg_pkg::S_SZA: begin
                if (i_stat.div_done) n_state = pwsg_pkg::S_SZB;
            end
            pwsg_pkg::S_SZB: begin
                if (i_stat.div_done) n_state = pwsg_pkg::S_SZFIN;
            end
            pwsg_pkg::S_SZFIN: begin
                n_state = pwsg_pkg::S_IDLE;
            end
            default: begin
                n_state = pwsg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.div_op = pwsg_pkg::DIV_COL;
        o_in_stall   = (r_state != pwsg_pkg::S_IDLE);
        unique case (r_state)
            pwsg_pkg::S_IDLE: begin
                o_cmd.accept = i_in_valid;
            end
            pwsg_pkg::S_CHECK: begin
                o_cmd.div_start = !i_stat.scan_done;
                o_cmd.div_op    = pwsg_pkg::DIV_COL;
            end
            pwsg_pkg::S_COL: begin
                o_cmd.div_start = i_stat.div_done;
                o_cmd.div_op    = pwsg_pkg::DIV_ROW;
            end
            pwsg_pkg::S_ROW: begin
            end
            pwsg_pkg::S_EMIT: begin
                o_cmd.emit = i_stat.out_free;
            end
            pwsg_pkg::S_ADV: begin
                if (i_stat.adv_kind == pwsg_pkg::ADV_SHRINK) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_op    = pwsg_pkg::DIV_SHW;
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            pwsg_pkg::S_SHW: begin
                o_cmd.div_start = i_stat.div_done;
                o_cmd.div_op    = pwsg_pkg::DIV_SHH;
            end
            pwsg_pkg::S_SHH: begin
                o_cmd.div_start = i_stat.div_done;
                o_cmd.div_op    = pwsg_pkg::DIV_SZA;
            end
            pwsg_pkg::S_SZA: begin
                o_cmd.div_start = i_stat.div_done;
                o_cmd.div_op    = pwsg_pkg::DIV_SZB;
            end
            pwsg_pkg::S_SZB: begin
            end
            pwsg_pkg::S_SZFIN: begin
                o_cmd.size_fin = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/pwsg_dp.sv
// datapath: config registers, scan state, shared multiplier and divider, output word
// depends on pwsg_pkg and pwsg_div
module pwsg_dp #(
    parameter int DIM_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pwsg_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [pwsg_pkg::CFG_DAT_BITS-1:0]    i_cfg_data,
    input  logic                                 i_restart,
    input  logic                                 i_out_stall,
    input  pwsg_pkg::t_dp_cmd                    i_cmd,
    output pwsg_pkg::t_dp_stat                   o_stat,
    output logic                                 o_out_valid,
    output logic [DIM_BITS-1:0]                  o_orig_col,
    output logic [DIM_BITS-1:0]                  o_orig_row,
    output logic [DIM_BITS:0]                    o_orig_window_size,
    output logic [DIM_BITS-1:0]                  o_level_col,
    output logic [DIM_BITS-1:0]                  o_level_row,
    output logic [DIM_BITS-1:0]                  o_level_width,
    output logic [DIM_BITS-1:0]                  o_level_height,
    output logic [pwsg_pkg::LEVEL_BITS-1:0]      o_level_index,
    output logic                                 o_exhausted
);

    localparam int WB  = pwsg_pkg::WIN_BITS;
    localparam int RB  = pwsg_pkg::RATIO_BITS;
    localparam int LB  = pwsg_pkg::LEVEL_BITS;
    localparam int QS  = pwsg_pkg::Q_SHIFT;
    localparam int DW  = (2 * DIM_BITS > DIM_BITS + 13) ? 2 * DIM_BITS : DIM_BITS + 13;
    localparam int DVW = (DIM_BITS > RB) ? DIM_BITS : RB;
    localparam int OW  = DIM_BITS + 1;
    localparam int SW  = DIM_BITS + 2;
    localparam int CW  = ((DIM_BITS + QS > WB + RB) ? DIM_BITS + QS : WB + RB) + 1;
    localparam logic [OW-1:0]       WIN_MAX   = {OW{1'b1}};
    localparam logic [DIM_BITS-1:0] RST_IMG_W = DIM_BITS'(pwsg_pkg::RST_IMAGE_WIDTH);
    localparam logic [DIM_BITS-1:0] RST_IMG_H = DIM_BITS'(pwsg_pkg::RST_IMAGE_HEIGHT);

    // configuration
    logic [DIM_BITS-1:0] r_img_w, r_img_h;
    logic [WB-1:0]       r_win_w, r_win_h, r_step;
    logic [RB-1:0]       r_ratio;

    // scan state
    logic [DIM_BITS-1:0] r_lvl_w, r_lvl_h, r_col, r_row;
    logic [OW-1:0]       r_owin;
    logic [LB-1:0]       r_level;
    logic                r_done;

    // intermediate results
    logic [DIM_BITS-1:0] r_map_col, r_map_row;
    logic [DW-1:0]       r_sz_a, r_sz_b;
    pwsg_pkg::t_div_op   r_div_op;

    logic                r_out_valid;

    logic [DIM_BITS-1:0]   mul_a, mul_b;
    logic [2*DIM_BITS-1:0] prod;
    logic [DW-1:0]         dividend;
    logic [DVW-1:0]        divisor;
    logic                  div_done;
    logic [DW-1:0]         quotient;

    logic [SW-1:0]   col_end, row_end;
    logic            col_ok, row_ok, shrink_ok;
    logic [WB+RB-1:0] ww_r, wh_r;
    logic [CW-1:0]   lw_q, lh_q;
    pwsg_pkg::t_adv  adv_kind;
    logic [DW-1:0]   sz_max;
    logic [OW-1:0]   sz_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= RST_IMG_W;
            r_img_h <= RST_IMG_H;
            r_win_w <= pwsg_pkg::RST_WINDOW_WIDTH;
            r_win_h <= pwsg_pkg::RST_WINDOW_HEIGHT;
            r_step  <= pwsg_pkg::RST_SCAN_STEP;
            r_ratio <= pwsg_pkg::RST_RATIO_Q12;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pwsg_pkg::CFG_IMAGE_WIDTH:   r_img_w <= i_cfg_data[DIM_BITS-1:0];
                pwsg_pkg::CFG_IMAGE_HEIGHT:  r_img_h <= i_cfg_data[DIM_BITS-1:0];
                pwsg_pkg::CFG_WINDOW_WIDTH:  r_win_w <= i_cfg_data[WB-1:0];
                pwsg_pkg::CFG_WINDOW_HEIGHT: r_win_h <= i_cfg_data[WB-1:0];
                pwsg_pkg::CFG_SCAN_STEP:     r_step  <= i_cfg_data[WB-1:0];
                pwsg_pkg::CFG_RATIO_Q12:     r_ratio <= i_cfg_data[RB-1:0];
                default: begin
                end
            endcase
        end
    end

    // shared multiplier feeding the divider operand register
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        dividend = '0;
        divisor  = '0;
        unique case (i_cmd.div_op)
            pwsg_pkg::DIV_COL: begin
                mul_a   = r_col;
                mul_b   = r_img_w;
                divisor = DVW'(r_lvl_w);
            end
            pwsg_pkg::DIV_ROW: begin
                mul_a   = r_row;
                mul_b   = r_img_h;
                divisor = DVW'(r_lvl_h);
            end
            pwsg_pkg::DIV_SZA: begin
                mul_a   = DIM_BITS'(r_win_w);
                mul_b   = r_img_w;
                divisor = DVW'(r_lvl_w);
            end
            pwsg_pkg::DIV_SZB: begin
                mul_a   = DIM_BITS'(r_win_h);
                mul_b   = r_img_h;
                divisor = DVW'(r_lvl_h);
            end
            pwsg_pkg::DIV_SHW: begin
                divisor = DVW'(r_ratio);
            end
            pwsg_pkg::DIV_SHH: begin
                divisor = DVW'(r_ratio);
            end
            default: begin
            end
        endcase
        prod = mul_a * mul_b;
        if (i_cmd.div_op == pwsg_pkg::DIV_SHW) begin
            dividend = DW'({r_lvl_w, {QS{1'b0}}}) + DW'(r_ratio) - DW'(1);
        end else if (i_cmd.div_op == pwsg_pkg::DIV_SHH) begin
            dividend = DW'({r_lvl_h, {QS{1'b0}}}) + DW'(r_ratio) - DW'(1);
        end else begin
            dividend = DW'(prod);
        end
    end

    pwsg_div #(
        .DW  (DW),
        .DVW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // advance decision
    assign col_end = SW'(r_col) + SW'(r_win_w) + SW'(r_step);
    assign row_end = SW'(r_row) + SW'(r_win_h) + SW'(r_step);
    assign col_ok  = (col_end <= SW'(r_lvl_w));
    assign row_ok  = (row_end <= SW'(r_lvl_h));
    assign ww_r    = r_win_w * r_ratio;
    assign wh_r    = r_win_h * r_ratio;
    assign lw_q    = CW'({r_lvl_w, {QS{1'b0}}});
    assign lh_q    = CW'({r_lvl_h, {QS{1'b0}}});
    assign shrink_ok = (r_ratio > pwsg_pkg::Q_ONE) && (r_level != pwsg_pkg::LEVEL_MAX) &&
                       (lw_q >= CW'(ww_r)) && (lh_q >= CW'(wh_r));

    always_comb begin
        priority if (col_ok) begin
            adv_kind = pwsg_pkg::ADV_COL;
        end else if (row_ok) begin
            adv_kind = pwsg_pkg::ADV_ROW;
        end else if (shrink_ok) begin
            adv_kind = pwsg_pkg::ADV_SHRINK;
        end else begin
            adv_kind = pwsg_pkg::ADV_END;
        end
    end

    assign sz_max = (r_sz_a > r_sz_b) ? r_sz_a : r_sz_b;
    assign sz_sat = (sz_max > DW'(WIN_MAX)) ? WIN_MAX : sz_max[OW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_op <= i_cmd.div_op;
        end
        if (div_done) begin
            unique case (r_div_op)
                pwsg_pkg::DIV_COL: r_map_col <= quotient[DIM_BITS-1:0];
                pwsg_pkg::DIV_ROW: r_map_row <= quotient[DIM_BITS-1:0];
                pwsg_pkg::DIV_SZA: r_sz_a    <= quotient;
                pwsg_pkg::DIV_SZB: r_sz_b    <= quotient;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_w <= RST_IMG_W;
            r_lvl_h <= RST_IMG_H;
            r_col   <= '0;
            r_row   <= '0;
            r_owin  <= OW'(pwsg_pkg::RST_WINDOW_WIDTH);
            r_level <= '0;
            r_done  <= 1'b0;
        end else if (i_cmd.accept && i_restart) begin
            r_lvl_w <= r_img_w;
            r_lvl_h <= r_img_h;
            r_col   <= '0;
            r_row   <= '0;
            r_owin  <= OW'(r_win_w);
            r_level <= '0;
            r_done  <= 1'b0;
        end else if (i_cmd.adv) begin
            unique case (adv_kind)
                pwsg_pkg::ADV_COL: begin
                    r_col <= r_col + DIM_BITS'(r_step);
                end
                pwsg_pkg::ADV_ROW: begin
                    r_col <= '0;
                    r_row <= r_row + DIM_BITS'(r_step);
                end
                default: begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_done <= 1'b1;
                end
            endcase
        end else if (i_cmd.size_fin) begin
            r_owin  <= sz_sat;
            r_level <= r_level + LB'(1);
            r_col   <= '0;
            r_row   <= '0;
        end else if (div_done && r_div_op == pwsg_pkg::DIV_SHW) begin
            r_lvl_w <= quotient[DIM_BITS-1:0];
        end else if (div_done && r_div_op == pwsg_pkg::DIV_SHH) begin
            r_lvl_h <= quotient[DIM_BITS-1:0];
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_done) begin
                o_orig_col         <= '0;
                o_orig_row         <= '0;
                o_orig_window_size <= '0;
                o_level_col        <= '0;
                o_level_row        <= '0;
                o_level_width      <= '0;
                o_level_height     <= '0;
                o_level_index      <= '0;
                o_exhausted        <= 1'b1;
            end else begin
                o_orig_col         <= r_map_col;
                o_orig_row         <= r_map_row;
                o_orig_window_size <= r_owin;
                o_level_col        <= r_col;
                o_level_row        <= r_row;
                o_level_width      <= r_lvl_w;
                o_level_height     <= r_lvl_h;
                o_level_index      <= r_level;
                o_exhausted        <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_stat.div_done  = div_done;
    assign o_stat.scan_done = r_done;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.adv_kind  = adv_kind;

endmodule

FILE: rtl/pyramid_window_scan_generator_top.sv
// Window scan generator over an image pyramid, coordinates only. Each accepted request
// word yields one result word: the window corner at the current level, the corner mapped
// back to the original image and the window side in original pixels, or an exhausted word.
// One request is worked at a time; a single radix-2 divider producing one quotient bit per
// cycle sets the latency, with a dividend of DW = max(2*DIM_BITS, DIM_BITS+13) bits (25 at
// the default). A window word waits for the column and row mappings, each a division; a
// window that closes a level also holds off the next request for the two level shrinks and
// two window-size quotients; an exhausted word needs no division. The next request is taken
// while the previous word waits at the output. The configuration port is always ready;
// write only while the block is idle.
// top level; depends on pwsg_pkg, pwsg_ctrl, pwsg_dp, pwsg_div
module pyramid_window_scan_generator_top #(
    parameter int DIM_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pwsg_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [pwsg_pkg::CFG_DAT_BITS-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_restart,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [DIM_BITS-1:0]                o_orig_col,
    output logic [DIM_BITS-1:0]                o_orig_row,
    output logic [DIM_BITS:0]                  o_orig_window_size,
    output logic [DIM_BITS-1:0]                o_level_col,
    output logic [DIM_BITS-1:0]                o_level_row,
    output logic [DIM_BITS-1:0]                o_level_width,
    output logic [DIM_BITS-1:0]                o_level_height,
    output logic [pwsg_pkg::LEVEL_BITS-1:0]    o_level_index,
    output logic                               o_exhausted
);

    pwsg_pkg::t_dp_cmd  cmd;
    pwsg_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    pwsg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pwsg_dp #(
        .DIM_BITS (DIM_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_restart          (i_restart),
        .i_out_stall        (i_out_stall),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_out_valid        (o_out_valid),
        .o_orig_col         (o_orig_col),
        .o_orig_row         (o_orig_row),
        .o_orig_window_size (o_orig_window_size),
        .o_level_col        (o_level_col),
        .o_level_row        (o_level_row),
        .o_level_width      (o_level_width),
        .o_level_height     (o_level_height),
        .o_level_index      (o_level_index),
        .o_exhausted        (o_exhausted)
    );

endmodule

FILE: test/tb.sv
// testbench of pyramid_window_scan_generator_top: a queue-fed driver, a scan predictor and a
// monitor that checks every result word field by field over several register settings
// depends on pwsg_pkg and pyramid_window_scan_generator_top
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [11:0] orig_col;
        logic [11:0] orig_row;
        logic [12:0] orig_win;
        logic [11:0] lvl_col;
        logic [11:0] lvl_row;
        logic [11:0] lvl_w;
        logic [11:0] lvl_h;
        logic [5:0]  lvl_idx;
        logic        exhausted;
    } t_window;

    typedef struct packed {
        logic restart;
        logic drain;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_restart = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [11:0] o_orig_col;
    logic [11:0] o_orig_row;
    logic [12:0] o_orig_window_size;
    logic [11:0] o_level_col;
    logic [11:0] o_level_row;
    logic [11:0] o_level_width;
    logic [11:0] o_level_height;
    logic [5:0]  o_level_index;
    logic        o_exhausted;

    pyramid_window_scan_generator_top DUT (.*);

    always #5 i_clk = ~i_clk;

    t_request request_q[$];
    t_window  window_q[$];
    int       errors = 0;
    int       idle_pct = 7;

    // register copy
    logic [11:0] cfg_iw, cfg_ih;
    logic [7:0]  cfg_ww, cfg_wh, cfg_step;
    logic [15:0] cfg_ratio;

    // scan state copy
    logic [11:0] sc_lw, sc_lh, sc_col, sc_row;
    logic [12:0] sc_win;
    logic [5:0]  sc_lvl;
    logic        sc_done;

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void load_scan();
        sc_lw   = cfg_iw;
        sc_lh   = cfg_ih;
        sc_col  = '0;
        sc_row  = '0;
        sc_win  = 13'(cfg_ww);
        sc_lvl  = '0;
        sc_done = 1'b0;
    endfunction

    function automatic void apply_cfg(input logic [2:0] idx, input logic [15:0] d);
        case (idx)
            pwsg_pkg::CFG_IMAGE_WIDTH:   cfg_iw = d[11:0];
            pwsg_pkg::CFG_IMAGE_HEIGHT:  cfg_ih = d[11:0];
            pwsg_pkg::CFG_WINDOW_WIDTH:  cfg_ww = d[7:0];
            pwsg_pkg::CFG_WINDOW_HEIGHT: cfg_wh = d[7:0];
            pwsg_pkg::CFG_SCAN_STEP:     cfg_step = d[7:0];
            pwsg_pkg::CFG_RATIO_Q12:     cfg_ratio = d;
            default: ;
        endcase
    endfunction

    function automatic logic [11:0] map_pos(input logic [11:0] pos, input logic [11:0] orig,
                                            input logic [11:0] lvl);
        if (lvl == 0)
            return '0;
        return 12'((64'(pos) * 64'(orig)) / 64'(lvl));
    endfunction

    function automatic logic [11:0] shrunk(input logic [11:0] d);
        return 12'((64'(d) * 64'(pwsg_pkg::Q_ONE) + 64'(cfg_ratio) - 64'd1) / 64'(cfg_ratio));
    endfunction

    function automatic logic [63:0] side_term(input logic [7:0] win, input logic [11:0] orig,
                                              input logic [11:0] dim);
        if (dim == 0)
            return '0;
        return (64'(win) * 64'(orig)) / 64'(dim);
    endfunction

    function automatic logic fits_shrunk();
        if (cfg_ratio <= pwsg_pkg::Q_ONE || sc_lvl >= pwsg_pkg::LEVEL_MAX)
            return 1'b0;
        return (64'(sc_lw) * 64'(pwsg_pkg::Q_ONE) >= 64'(cfg_ww) * 64'(cfg_ratio)) &&
               (64'(sc_lh) * 64'(pwsg_pkg::Q_ONE) >= 64'(cfg_wh) * 64'(cfg_ratio));
    endfunction

    function automatic void step_scan();
        logic [63:0] a, b, m;
        if (32'(sc_col) + 32'(cfg_ww) + 32'(cfg_step) <= 32'(sc_lw)) begin
            sc_col = sc_col + 12'(cfg_step);
        end else if (32'(sc_row) + 32'(cfg_wh) + 32'(cfg_step) <= 32'(sc_lh)) begin
            sc_col = '0;
            sc_row = sc_row + 12'(cfg_step);
        end else if (fits_shrunk()) begin
            sc_lw  = shrunk(sc_lw);
            sc_lh  = shrunk(sc_lh);
            a      = side_term(cfg_ww, cfg_iw, sc_lw);
            b      = side_term(cfg_wh, cfg_ih, sc_lh);
            m      = (a > b) ? a : b;
            sc_win = (m > 64'd8191) ? 13'd8191 : 13'(m);
            sc_lvl = sc_lvl + 6'd1;
            sc_col = '0;
            sc_row = '0;
        end else begin
            sc_col  = '0;
            sc_row  = '0;
            sc_done = 1'b1;
        end
    endfunction

    function automatic t_window scan_next(input logic restart);
        t_window w;
        if (restart)
            load_scan();
        w = '0;
        if (sc_done) begin
            w.exhausted = 1'b1;
            return w;
        end
        w.orig_col = map_pos(sc_col, cfg_iw, sc_lw);
        w.orig_row = map_pos(sc_row, cfg_ih, sc_lh);
        w.orig_win = sc_win;
        w.lvl_col  = sc_col;
        w.lvl_row  = sc_row;
        w.lvl_w    = sc_lw;
        w.lvl_h    = sc_lh;
        w.lvl_idx  = sc_lvl;
        step_scan();
        return w;
    endfunction

    // driver of request words, predictor updated on every accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_restart  <= 1'b0;
            cfg_iw     = 12'(pwsg_pkg::RST_IMAGE_WIDTH);
            cfg_ih     = 12'(pwsg_pkg::RST_IMAGE_HEIGHT);
            cfg_ww     = pwsg_pkg::RST_WINDOW_WIDTH;
            cfg_wh     = pwsg_pkg::RST_WINDOW_HEIGHT;
            cfg_step   = pwsg_pkg::RST_SCAN_STEP;
            cfg_ratio  = pwsg_pkg::RST_RATIO_Q12;
            load_scan();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                apply_cfg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                window_q.push_back(scan_next(i_restart));
            if (!i_in_valid || !o_in_stall) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                    !(request_q[0].drain && window_q.size() != 0)) begin
                    i_in_valid <= 1'b1;
                    i_restart  <= request_q[0].restart;
                    void'(request_q.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor of result words
    always @(posedge i_clk) begin : mon
        t_window want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (window_q.size() == 0) begin
                    report("unexpected word", 0, 0);
                end else begin
                    want = window_q.pop_front();
                    if (o_orig_col !== want.orig_col)
                        report("orig_col", o_orig_col, want.orig_col);
                    if (o_orig_row !== want.orig_row)
                        report("orig_row", o_orig_row, want.orig_row);
                    if (o_orig_window_size !== want.orig_win)
                        report("orig_window_size", o_orig_window_size, want.orig_win);
                    if (o_level_col !== want.lvl_col)
                        report("level_col", o_level_col, want.lvl_col);
                    if (o_level_row !== want.lvl_row)
                        report("level_row", o_level_row, want.lvl_row);
                    if (o_level_width !== want.lvl_w)
                        report("level_width", o_level_width, want.lvl_w);
                    if (o_level_height !== want.lvl_h)
                        report("level_height", o_level_height, want.lvl_h);
                    if (o_level_index !== want.lvl_idx)
                        report("level_index", o_level_index, want.lvl_idx);
                    if (o_exhausted !== want.exhausted)
                        report("exhausted", o_exhausted, want.exhausted);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    // block is idle only once it stops stalling, a level shrink runs after the last word
    task automatic wait_idle();
        while (request_q.size() != 0 || i_in_valid || window_q.size() != 0 || o_in_stall)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input pwsg_pkg::t_cfg_reg idx, input logic [15:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_scan(input logic [11:0] iw, input logic [11:0] ih,
                            input logic [7:0] ww, input logic [7:0] wh,
                            input logic [7:0] st, input logic [15:0] ra);
        wait_idle();
        write_reg(pwsg_pkg::CFG_IMAGE_WIDTH, 16'(iw));
        write_reg(pwsg_pkg::CFG_IMAGE_HEIGHT, 16'(ih));
        write_reg(pwsg_pkg::CFG_WINDOW_WIDTH, 16'(ww));
        write_reg(pwsg_pkg::CFG_WINDOW_HEIGHT, 16'(wh));
        write_reg(pwsg_pkg::CFG_SCAN_STEP, 16'(st));
        write_reg(pwsg_pkg::CFG_RATIO_Q12, ra);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_req(input logic restart, input logic drain);
        t_request r;
        r.restart = restart;
        r.drain   = drain;
        request_q.push_back(r);
    endtask

    // first word restarts the scan, then mostly plain requests
    task automatic queue_scan(input int n, input int drain_at);
        for (int i = 0; i < n; i++)
            push_req((i == 0) || ($urandom_range(0, 99) < 3), i == drain_at);
    endtask

    initial begin
        int sent;
        int ph;
        int n;
        logic [7:0]  st, ww, wh;
        logic [11:0] iw, ih;
        sent = 0;
        ph   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // scan state straight out of reset
        repeat (3) push_req(1'b0, 1'b0);
        // largest image, window, step and ratio
        set_scan(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 16'hFFFF);
        queue_scan(3, -1);
        // window larger than the image
        set_scan(12'd1, 12'd1, 8'd255, 8'd255, 8'd1, 16'd4915);
        queue_scan(3, -1);
        // zero step repeats the window
        set_scan(12'd7, 12'd5, 8'd2, 8'd2, 8'd0, 16'd4915);
        queue_scan(3, -1);
        // zero level width
        set_scan(12'd0, 12'd9, 8'd1, 8'd1, 8'd1, 16'd8192);
        queue_scan(4, -1);
        // zero window and zero ratio
        set_scan(12'd12, 12'd12, 8'd0, 8'd0, 8'd3, 16'd0);
        queue_scan(3, -1);
        // ratio of exactly one never shrinks, restart mid scan, sender drains first
        set_scan(12'd4, 12'd4, 8'd2, 8'd2, 8'd2, 16'd4096);
        push_req(1'b1, 1'b0);
        push_req(1'b0, 1'b0);
        push_req(1'b0, 1'b1);
        push_req(1'b1, 1'b0);
        push_req(1'b0, 1'b0);
        push_req(1'b0, 1'b0);
        push_req(1'b0, 1'b0);
        push_req(1'b0, 1'b0);

        // one window per level until the level cap
        set_scan(12'd256, 12'd256, 8'd255, 8'd255, 8'd255, 16'd4097);
        queue_scan(70, 40);
        sent += 70;

        while (sent < 550) begin
            ph++;
            idle_pct = (ph % 6 == 3) ? 0 : 7;
            case ($urandom_range(0, 15))
                0: begin
                    set_scan(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, 16'hFFFF);
                    n = 12;
                end
                1: begin
                    set_scan(12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 16'($urandom));
                    n = 12;
                end
                2: begin
                    st = 8'($urandom_range(1, 8));
                    set_scan(12'($urandom_range(1, 30)), 12'($urandom_range(1, 30)),
                             8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)), st,
                             16'($urandom_range(0, 4096)));
                    n = 30;
                end
                default: begin
                    st = 8'($urandom_range(1, 32));
                    ww = 8'($urandom_range(1, 40));
                    wh = 8'($urandom_range(1, 40));
                    iw = 12'(ww) + 12'($urandom_range(0, 6 * st));
                    ih = 12'(wh) + 12'($urandom_range(0, 6 * st));
                    set_scan(iw, ih, ww, wh, st, 16'($urandom_range(4097, 12288)));
                    n = $urandom_range(20, 80);
                end
            endcase
            queue_scan(n, ($urandom_range(0, 2) == 0) ? $urandom_range(1, n - 1) : -1);
            sent += n;
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && window_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
